FILE: sv/sohpf_pkg.sv
// Package for the second-order high-pass filter: widths, payload structs,
// controller states and the command/status structs between control and datapath.
// No dependencies.
package sohpf_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int STEP_WIDTH      = 16;
   localparam int CFG_WIDTH       = 32;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam int SCALE_SHIFT = 2 * STEP_WIDTH;
   localparam int T1S_WIDTH   = CFG_WIDTH + STEP_WIDTH;
   localparam int T2DT_WIDTH  = CFG_WIDTH + STEP_WIDTH;
   localparam int DTSQ_WIDTH  = 2 * STEP_WIDTH;
   localparam int DEN_WIDTH   = T1S_WIDTH + 2;
   localparam int COEF_WIDTH  = T1S_WIDTH + 2;
   localparam int DIFF_WIDTH  = DATA_WIDTH + 2;
   localparam int NUM_WIDTH   = DATA_WIDTH + COEF_WIDTH + 2;
   localparam int MUL_B_WIDTH = 32;
   localparam int PROD_WIDTH  = DATA_WIDTH + MUL_B_WIDTH + 1;
   localparam int CNT_WIDTH   = $clog2(DATA_WIDTH);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_CONST_ONE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_CONST_TWO = 1'b1;

   localparam logic [CFG_WIDTH-1:0] TIME_CONST_RESET = CFG_WIDTH'(65536);

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sample_in;
      logic [STEP_WIDTH-1:0]        time_step;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sample_out;
      logic                         invalid;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_COEF,
      ST_MUL_A,
      ST_ACC_A,
      ST_MUL_B,
      ST_ACC_B,
      ST_MUL_C,
      ST_ACC_C,
      ST_SIGN,
      ST_CHECK,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MUL_Y1_LO,
      MUL_Y1_HI,
      MUL_Y2_T1
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       prep;
      logic       coef;
      logic       mul;
      logic       accum;
      mul_op_type op;
      logic       sign;
      logic       check;
      logic       div_step;
      logic       finish;
   } dp_cmd_type;

   typedef struct packed {
      logic den_zero;
      logic over;
   } dp_status_type;

endpackage

FILE: sv/sohpf_dp.sv
// Datapath of the high-pass filter: configuration registers, history,
// shared multiplier with accumulator, restoring divider and saturation.
// Depends on sohpf_pkg.
module sohpf_dp (
   input  logic                                    clock,
   input  logic                                    reset,
   input  sohpf_pkg::req_type                      req_data,
   input  logic                                    csr_we,
   input  logic [sohpf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [sohpf_pkg::CFG_WIDTH-1:0]         csr_wdata,
   input  sohpf_pkg::dp_cmd_type                   cmd,
   output sohpf_pkg::dp_status_type                status,
   output sohpf_pkg::rsp_type                      rsp_data
);
   import sohpf_pkg::*;

   localparam logic [DATA_WIDTH-1:0] LIM = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic [CFG_WIDTH-1:0]          t1_ff, t1_in, t2_ff, t2_in;
   logic signed [DATA_WIDTH-1:0]  x_ff, x_in, x1_ff, x1_in, x2_ff, x2_in;
   logic signed [DATA_WIDTH-1:0]  y1_ff, y1_in, y2_ff, y2_in;
   logic [STEP_WIDTH-1:0]         dt_ff, dt_in;
   logic [T1S_WIDTH-1:0]          t1s_ff, t1s_in;
   logic [T2DT_WIDTH-1:0]         t2dt_ff, t2dt_in;
   logic [DTSQ_WIDTH-1:0]         dtsq_ff, dtsq_in;
   logic [DEN_WIDTH-1:0]          den_ff, den_in;
   logic [COEF_WIDTH-1:0]         coef_ff, coef_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic signed [NUM_WIDTH-1:0]   acc_ff, acc_in;
   logic                          neg_ff, neg_in;
   logic [NUM_WIDTH-1:0]          mag_ff, mag_in;
   logic                          den_zero_ff, den_zero_in, over_ff, over_in;
   logic [DEN_WIDTH-1:0]          rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]         dvd_ff, dvd_in;
   rsp_type                       rsp_ff, rsp_in;

   logic signed [DIFF_WIDTH-1:0]  diff;
   logic signed [DATA_WIDTH-1:0]  mul_a;
   logic [MUL_B_WIDTH-1:0]        mul_b;
   logic signed [MUL_B_WIDTH:0]   mul_b_s;
   logic signed [NUM_WIDTH-1:0]   term;
   logic [DEN_WIDTH:0]            trial;
   logic                          trial_ge;
   logic signed [DATA_WIDTH-1:0]  y_sat;

   always_comb begin
      diff = DIFF_WIDTH'(x_ff) - (DIFF_WIDTH'(x1_ff) <<< 1) + DIFF_WIDTH'(x2_ff);

      mul_a = y1_ff;
      mul_b = coef_ff[MUL_B_WIDTH-1:0];
      term  = NUM_WIDTH'(prod_ff);
      unique case (cmd.op)
         MUL_Y1_LO: begin
            mul_a = y1_ff;
            mul_b = coef_ff[MUL_B_WIDTH-1:0];
            term  = NUM_WIDTH'(prod_ff);
         end
         MUL_Y1_HI: begin
            mul_a = y1_ff;
            mul_b = MUL_B_WIDTH'(coef_ff[COEF_WIDTH-1:MUL_B_WIDTH]);
            term  = NUM_WIDTH'(prod_ff) <<< MUL_B_WIDTH;
         end
         MUL_Y2_T1: begin
            mul_a = y2_ff;
            mul_b = MUL_B_WIDTH'(t1_ff);
            term  = NUM_WIDTH'(prod_ff) <<< STEP_WIDTH;
         end
         default: begin
            mul_a = y1_ff;
            mul_b = coef_ff[MUL_B_WIDTH-1:0];
            term  = NUM_WIDTH'(prod_ff);
         end
      endcase
      mul_b_s = $signed({1'b0, mul_b});

      trial    = {rem_ff, dvd_ff[DATA_WIDTH-1]};
      trial_ge = trial >= {1'b0, den_ff};

      if (den_zero_ff) begin
         y_sat = '0;
      end else if (neg_ff) begin
         if (over_ff || (dvd_ff > LIM)) begin
            y_sat = $signed(LIM);
         end else begin
            y_sat = $signed(-dvd_ff);
         end
      end else begin
         if (over_ff || dvd_ff[DATA_WIDTH-1]) begin
            y_sat = $signed(~LIM);
         end else begin
            y_sat = $signed(dvd_ff);
         end
      end
   end

   always_comb begin
      t1_in       = t1_ff;
      t2_in       = t2_ff;
      x_in        = x_ff;
      dt_in       = dt_ff;
      x1_in       = x1_ff;
      x2_in       = x2_ff;
      y1_in       = y1_ff;
      y2_in       = y2_ff;
      t1s_in      = t1s_ff;
      t2dt_in     = t2dt_ff;
      dtsq_in     = dtsq_ff;
      den_in      = den_ff;
      coef_in     = coef_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      mag_in      = mag_ff;
      den_zero_in = den_zero_ff;
      over_in     = over_ff;
      rem_in      = rem_ff;
      dvd_in      = dvd_ff;
      rsp_in      = rsp_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_TIME_CONST_ONE: t1_in = csr_wdata;
            CSR_TIME_CONST_TWO: t2_in = csr_wdata;
            default:            t1_in = t1_ff;
         endcase
      end
      if (cmd.load) begin
         x_in  = req_data.sample_in;
         dt_in = req_data.time_step;
      end
      if (cmd.prep) begin
         t1s_in  = {t1_ff, {STEP_WIDTH{1'b0}}};
         t2dt_in = T2DT_WIDTH'(t2_ff) * T2DT_WIDTH'(dt_ff);
         dtsq_in = DTSQ_WIDTH'(dt_ff) * DTSQ_WIDTH'(dt_ff);
         acc_in  = NUM_WIDTH'(diff) <<< SCALE_SHIFT;
      end
      if (cmd.coef) begin
         den_in  = DEN_WIDTH'(t1s_ff) + DEN_WIDTH'(t2dt_ff) + DEN_WIDTH'(dtsq_ff);
         coef_in = (COEF_WIDTH'(t1s_ff) << 1) + COEF_WIDTH'(t2dt_ff);
      end
      if (cmd.mul) begin
         prod_in = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b_s);
      end
      if (cmd.accum) begin
         if (cmd.op == MUL_Y2_T1) begin
            acc_in = acc_ff - term;
         end else begin
            acc_in = acc_ff + term;
         end
      end
      if (cmd.sign) begin
         neg_in = acc_ff[NUM_WIDTH-1];
         mag_in = acc_ff[NUM_WIDTH-1] ? NUM_WIDTH'(-acc_ff) : NUM_WIDTH'(acc_ff);
      end
      if (cmd.check) begin
         den_zero_in = (den_ff == '0);
         over_in     = mag_ff >= (NUM_WIDTH'(den_ff) << DATA_WIDTH);
         rem_in      = DEN_WIDTH'(mag_ff >> DATA_WIDTH);
         dvd_in      = mag_ff[DATA_WIDTH-1:0];
      end
      if (cmd.div_step) begin
         rem_in = trial_ge ? DEN_WIDTH'(trial - {1'b0, den_ff}) : trial[DEN_WIDTH-1:0];
         dvd_in = {dvd_ff[DATA_WIDTH-2:0], trial_ge};
      end
      if (cmd.finish) begin
         x2_in  = x1_ff;
         x1_in  = x_ff;
         y2_in  = y1_ff;
         y1_in  = y_sat;
         rsp_in = '{sample_out: y_sat, invalid: den_zero_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= TIME_CONST_RESET;
         t2_ff <= TIME_CONST_RESET;
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else begin
         t1_ff <= t1_in;
         t2_ff <= t2_in;
         x1_ff <= x1_in;
         x2_ff <= x2_in;
         y1_ff <= y1_in;
         y2_ff <= y2_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      dt_ff       <= dt_in;
      t1s_ff      <= t1s_in;
      t2dt_ff     <= t2dt_in;
      dtsq_ff     <= dtsq_in;
      den_ff      <= den_in;
      coef_ff     <= coef_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      den_zero_ff <= den_zero_in;
      over_ff     <= over_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      rsp_ff      <= rsp_in;
   end

   assign status.den_zero = den_zero_ff;
   assign status.over     = over_ff;
   assign rsp_data        = rsp_ff;

endmodule

FILE: sv/sohpf_ctrl.sv
// Controller of the high-pass filter: sequences prep, multiply-accumulate,
// division and result handoff; owns the handshakes. Depends on sohpf_pkg.
module sohpf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  sohpf_pkg::dp_status_type status,
   output sohpf_pkg::dp_cmd_type    cmd
);
   import sohpf_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.op       = MUL_Y1_LO;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_COEF;
         end
         ST_COEF: begin
            cmd.coef = 1'b1;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            cmd.mul  = 1'b1;
            cmd.op   = MUL_Y1_LO;
            state_in = ST_ACC_A;
         end
         ST_ACC_A: begin
            cmd.accum = 1'b1;
            cmd.op    = MUL_Y1_LO;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul  = 1'b1;
            cmd.op   = MUL_Y1_HI;
            state_in = ST_ACC_B;
         end
         ST_ACC_B: begin
            cmd.accum = 1'b1;
            cmd.op    = MUL_Y1_HI;
            state_in  = ST_MUL_C;
         end
         ST_MUL_C: begin
            cmd.mul  = 1'b1;
            cmd.op   = MUL_Y2_T1;
            state_in = ST_ACC_C;
         end
         ST_ACC_C: begin
            cmd.accum = 1'b1;
            cmd.op    = MUL_Y2_T1;
            state_in  = ST_SIGN;
         end
         ST_SIGN: begin
            cmd.sign = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            cnt_in    = CNT_WIDTH'(DATA_WIDTH - 1);
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CNT_WIDTH'(1);
            if ((cnt_ff == '0) || status.den_zero || status.over) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_PREP))
      else $error("accepted item did not start processing");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished item not presented");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |=> ((state_ff == ST_DIV) &&
                                  (cnt_ff == CNT_WIDTH'(DATA_WIDTH - 1))))
      else $error("divider not started with full count");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.prep, cmd.coef, cmd.mul, cmd.accum, cmd.sign,
                cmd.check, cmd.div_step, cmd.finish}))
      else $error("more than one datapath command");

endmodule

FILE: sv/second_order_highpass_filter.sv
// Top level of the second-order high-pass IIR filter with variable time step.
// Joins sohpf_ctrl and sohpf_dp. Depends on sohpf_pkg.
//
//   Channel   Ports                               Dir   Carries
//   request   req_valid, req_stall, req_data      in    sample_in, time_step
//   response  rsp_valid, rsp_stall, rsp_data      out   sample_out, invalid
//   config    csr_we, csr_index, csr_wdata        in    time_const_one/two
//
// Each item passes through product preparation, coefficient sums, multiply-accumulate
// on one shared multiplier and sign handling, a 32-step restoring divider and
// loading of the output register, then returns to idle to accept the next item.
// A zero denominator or a saturating quotient cuts the divider to one step.
// Reset clears the history and loads both time constants with 1.0.
// A stalled result waits in the output register while the next item computes;
// that item then holds in its last step until the waiting result is taken.
module second_order_highpass_filter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  sohpf_pkg::req_type                     req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output sohpf_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_we,
   input  logic [sohpf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [sohpf_pkg::CFG_WIDTH-1:0]        csr_wdata
);
   import sohpf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   sohpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sohpf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for second_order_highpass_filter: directed and random items
// on the request channel, results checked against an internal Q16.16 filter predictor.
// Depends on sohpf_pkg and the second_order_highpass_filter RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sohpf_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 60;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CFG_WIDTH-1:0] csr_wdata;

   logic [31:0] t1_setting;
   logic [31:0] t2_setting;
   logic signed [31:0] prev_in;
   logic signed [31:0] prev_in2;
   logic signed [31:0] prev_out;
   logic signed [31:0] prev_out2;

   rsp_type pending_outputs[$];
   rsp_type want;
   int errors = 0;
   int quiet_cycles = 0;
   bit idle_on = 1'b1;
   bit hold_output = 1'b0;
   bit sending = 1'b0;

   second_order_highpass_filter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic rsp_type highpass_predict(input req_type item);
      logic signed [127:0] xw, x1w, x2w, y1w, y2w, diff, num;
      logic [127:0] mag, quo;
      logic [63:0] dt, t1s, t2dt, den;
      rsp_type r;
      dt = 64'(item.time_step);
      t1s = 64'(t1_setting) << 16;
      t2dt = 64'(t2_setting) * dt;
      den = t1s + t2dt + dt * dt;
      r.sample_out = '0;
      r.invalid = 1'b0;
      if (den == 64'd0) begin
         r.invalid = 1'b1;
      end else begin
         xw = $signed(item.sample_in);
         x1w = prev_in;
         x2w = prev_in2;
         y1w = prev_out;
         y2w = prev_out2;
         diff = xw - (x1w <<< 1) + x2w;
         num = (diff <<< 32) + y1w * $signed({64'd0, 64'(2 * t1s + t2dt)})
               - y2w * $signed({64'd0, t1s});
         mag = num[127] ? 128'(-num) : 128'(num);
         quo = mag / {64'd0, den};
         if (num[127]) begin
            if (quo > 128'h8000_0000) quo = 128'h8000_0000;
            r.sample_out = 32'd0 - quo[31:0];
         end else begin
            if (quo > 128'h7FFF_FFFF) quo = 128'h7FFF_FFFF;
            r.sample_out = quo[31:0];
         end
      end
      prev_in2 = prev_in;
      prev_in = item.sample_in;
      prev_out2 = prev_out;
      prev_out = r.sample_out;
      return r;
   endfunction

   task automatic send_item(input logic [31:0] sample, input logic [15:0] step);
      req_type item;
      int gap;
      item.sample_in = sample;
      item.time_step = step;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         if (sending) req_valid <= 1'b0;
         sending = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      sending = 1'b1;
      do @(posedge clock); while (req_stall);
      pending_outputs.push_back(highpass_predict(item));
   endtask

   task automatic finish_results();
      if (sending) req_valid <= 1'b0;
      sending = 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic program_time_consts(input logic [31:0] t1, input logic [31:0] t2);
      finish_results();
      repeat (50) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_TIME_CONST_ONE;
      csr_wdata <= t1;
      @(posedge clock);
      csr_index <= CSR_TIME_CONST_TWO;
      csr_wdata <= t2;
      @(posedge clock);
      csr_we <= 1'b0;
      t1_setting = t1;
      t2_setting = t2;
   endtask

   task automatic check_reset_response();
      send_item(32'h7FFF_FFFF, 16'hFFFF);
      send_item(32'h8000_0000, 16'hFFFF);
      send_item(32'h0000_0000, 16'h0000);
      send_item(32'h0001_0000, 16'h0001);
      send_item(32'h0000_0000, 16'h0100);
      send_item(32'h7FFF_FFFF, 16'h0000);
      send_item(32'h8000_0000, 16'h0000);
      finish_results();
   endtask

   task automatic check_zero_denominator();
      program_time_consts(32'd0, $urandom());
      send_item(32'h1234_5678, 16'h0000);
      send_item($urandom(), 16'h0001);
      send_item($urandom(), 16'h0000);
      program_time_consts(32'd0, 32'd0);
      send_item($urandom(), 16'hFFFF);
      send_item($urandom(), 16'h0000);
      finish_results();
   endtask

   task automatic check_saturation();
      program_time_consts(32'd1, 32'd0);
      send_item(32'h7FFF_FFFF, 16'h0000);
      send_item(32'h8000_0000, 16'h0000);
      send_item(32'h4000_0000, 16'h0000);
      send_item(32'hFFFF_FFFF, 16'h0000);
      program_time_consts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(32'h7FFF_FFFF, 16'hFFFF);
      send_item(32'h8000_0000, 16'hFFFF);
      send_item(32'h0000_0000, 16'h0000);
      program_time_consts(32'd0, 32'hFFFF_FFFF);
      send_item(32'h7FFF_FFFF, 16'h0001);
      send_item(32'h8000_0000, 16'h0001);
      finish_results();
   endtask

   task automatic check_output_backpressure();
      program_time_consts(TIME_CONST_RESET, TIME_CONST_RESET);
      idle_on = 1'b0;
      hold_output = 1'b1;
      repeat (12) send_item($urandom(), 16'($urandom()));
      finish_results();
      idle_on = 1'b1;
   endtask

   task automatic check_sender_pause();
      repeat (5) send_item($urandom(), 16'($urandom()));
      finish_results();
      repeat (5) send_item($urandom(), 16'($urandom()));
      finish_results();
   endtask

   task automatic run_random_phase(input logic [31:0] t1, input logic [31:0] t2,
                                   input int count);
      logic [31:0] level;
      logic [31:0] sample;
      logic [15:0] step;
      int pick;
      program_time_consts(t1, t2);
      level = '0;
      repeat (count) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            level = level + 32'($urandom_range(0, 8191)) - 32'd4096;
            sample = level;
            step = 16'($urandom_range(1, 4000));
         end else if (pick < 9) begin
            sample = $urandom();
            step = 16'($urandom());
         end else begin
            case ($urandom_range(0, 3))
               0: sample = 32'h7FFF_FFFF;
               1: sample = 32'h8000_0000;
               2: sample = 32'h0000_0000;
               default: sample = 32'hFFFF_FFFF;
            endcase
            case ($urandom_range(0, 2))
               0: step = 16'h0000;
               1: step = 16'hFFFF;
               default: step = 16'h0001;
            endcase
         end
         send_item(sample, step);
         if ($urandom_range(0, 39) == 0) finish_results();
      end
   endtask

   task automatic check_random_settings();
      run_random_phase(TIME_CONST_RESET, TIME_CONST_RESET, 100);
      run_random_phase(32'd0, $urandom(), 100);
      run_random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 100);
      idle_on = 1'b0;
      run_random_phase(32'd1, 32'd0, 100);
      idle_on = 1'b1;
      run_random_phase($urandom(), $urandom(), 100);
      run_random_phase($urandom_range(0, 65535), $urandom_range(0, 1 << 20), 100);
      run_random_phase(32'd0, 32'd0, 100);
      finish_results();
   endtask

   initial begin
      int gap;
      rsp_stall = 1'b1;
      wait (reset === 1'b0);
      forever begin
         if (hold_output) begin
            gap = HOLD_CYCLES;
            hold_output = 1'b0;
         end else begin
            gap = idle_on ? $urandom_range(0, 7) : 0;
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outputs.size() == 0) begin
            $display("%0t: result with no item outstanding: sample_out %0d invalid %0b",
                     $time, rsp_data.sample_out, rsp_data.invalid);
            errors++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_data.sample_out !== want.sample_out) begin
               $display("%0t: sample_out expected %0d actual %0d",
                        $time, want.sample_out, rsp_data.sample_out);
               errors++;
            end
            if (rsp_data.invalid !== want.invalid) begin
               $display("%0t: invalid expected %0b actual %0b",
                        $time, want.invalid, rsp_data.invalid);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_TIME_CONST_ONE;
      csr_wdata = '0;
      t1_setting = TIME_CONST_RESET;
      t2_setting = TIME_CONST_RESET;
      prev_in = '0;
      prev_in2 = '0;
      prev_out = '0;
      prev_out2 = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      check_reset_response();
      check_zero_denominator();
      check_saturation();
      check_output_backpressure();
      check_sender_pause();
      check_random_settings();
      finish_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

FILE: sim.f
sv/sohpf_pkg.sv
sv/sohpf_dp.sv
sv/sohpf_ctrl.sv
sv/second_order_highpass_filter.sv
tb/tb.sv
